### rtl/core/glhb_pkg.sv
// Shared types and constants for the gridded leaflet height binner.
// Depends on nothing; imported by every module in rtl/core.
package glhb_pkg;

  localparam int MaxTiles   = 4096;
  localparam int TileAw     = $clog2(MaxTiles);
  localparam int CountBits  = 24;
  localparam int SumW       = 48;
  localparam int CoordW     = 18;
  localparam int ZW         = 18;
  localparam int BinW       = 12;
  localparam int GridW      = 13;
  localparam int MeanW      = 17;
  localparam int OffW       = CoordW + 1;

  // Offset*10 + 500 over 1000 is (offset + 50) / 100.
  localparam logic [OffW-1:0] BinHalf  = OffW'(50);
  localparam logic [7:0]      BinDiv   = 8'd100;
  // floor(2^24 / 100); quotient estimate is exact or one low.
  localparam int              RecipSh  = 24;
  localparam logic [17:0]     BinRecip = 18'd167772;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] RegMinX  = 3'd0;
  localparam logic [2:0] RegMaxX  = 3'd1;
  localparam logic [2:0] RegMinY  = 3'd2;
  localparam logic [2:0] RegMaxY  = 3'd3;
  localparam logic [2:0] RegCols  = 3'd4;
  localparam logic [2:0] RegRows  = 3'd5;
  localparam logic [2:0] RegLimit = 3'd6;

  typedef struct packed {
    logic signed [SumW-1:0] usum;
    logic [CountBits-1:0]   ucnt;
    logic signed [SumW-1:0] lsum;
    logic [CountBits-1:0]   lcnt;
  } tile_ent_t;

endpackage

### rtl/core/glhb_tile_store.sv
// Tile store: one synchronous memory of per-tile sums and counts, with a
// clearing pass after reset. Depends on glhb_pkg.
module glhb_tile_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [glhb_pkg::TileAw-1:0]   rd_addr_i,
  output glhb_pkg::tile_ent_t           rd_data_o,
  input  logic                          wr_en_i,
  input  logic [glhb_pkg::TileAw-1:0]   wr_addr_i,
  input  glhb_pkg::tile_ent_t           wr_data_i,
  output logic                          busy_o
);
  import glhb_pkg::*;

  tile_ent_t         mem_q [MaxTiles];
  tile_ent_t         rd_data_q;
  logic              clr_busy_q;
  logic [TileAw-1:0] clr_addr_q;

  logic              we;
  logic [TileAw-1:0] wa;
  tile_ent_t         wd;

  // clearing pass owns the write port until it is done
  always_comb begin
    we = wr_en_i;
    wa = wr_addr_i;
    wd = wr_data_i;
    if (clr_busy_q) begin
      we = 1'b1;
      wa = clr_addr_q;
      wd = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {TileAw{1'b1}}) clr_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

### rtl/core/glhb_mean_div.sv
// Iterative mean divider: 17-bit saturating quotient of a 48-bit
// magnitude by a 24-bit count, one quotient bit a cycle. Depends on glhb_pkg.
module glhb_mean_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [glhb_pkg::SumW-1:0]      mag_i,
  input  logic [glhb_pkg::CountBits-1:0] den_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [glhb_pkg::MeanW-1:0]     quot_o
);
  import glhb_pkg::*;

  logic             run_q;
  logic             done_q;
  logic [4:0]       step_q;
  logic [SumW-1:0]  rem_q;
  logic [SumW-1:0]  dsh_q;
  logic [MeanW-1:0] q_q;
  logic             sat;
  logic             take;

  // quotient too large for 17 bits (also catches a zero count)
  assign sat  = mag_i >= (SumW'(den_i) << MeanW);
  assign take = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (sat) begin
          done_q <= 1'b1;
        end else begin
          run_q  <= 1'b1;
          step_q <= 5'(MeanW - 1);
        end
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= mag_i;
      dsh_q <= SumW'(den_i) << (MeanW - 1);
      q_q   <= sat ? {MeanW{1'b1}} : '0;
    end else if (run_q) begin
      if (take) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      q_q   <= {q_q[MeanW-2:0], take};
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign quot_o = q_q;

  property p_start_idle;
    @(posedge clk_i) disable iff (!rst_ni) start_i |-> !run_q;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("divider restarted while busy");

  property p_done_ends_run;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> !run_q;
  endproperty
  a_done_ends_run: assert property (p_done_ends_run) else $error("done while running");

  property p_step_bound;
    @(posedge clk_i) disable iff (!rst_ni) run_q |-> step_q < 5'(MeanW);
  endproperty
  a_step_bound: assert property (p_step_bound) else $error("divider step out of range");

endmodule

### rtl/core/gridded_leaflet_height_binner.sv
// Top level: APB registers, item sequencer and read-modify-write of the tile store.
// Depends on glhb_pkg, glhb_tile_store and glhb_mean_div.
//
//  channel  | dir | handshake               | beat
//  ---------+-----+-------------------------+--------------------------------------
//  in       | in  | in_valid_i / in_stall_o | kind, pos_x, pos_y, rel_z, read_col/row
//  out      | out | out_valid_o/out_stall_i | upper/lower mean+valid, out_of_range
//  apb      | in  | psel/penable/pready     | 7 registers at byte address 4*i
//
// One item at a time. A sample goes through binning, tile number, memory read
// and write back; one outside the window is dropped. A read goes through tile
// number, memory read, capture and divider start, then two divider runs and the
// output register; an out-of-range read skips the divider. After reset a
// clearing pass writes all 4096 tiles, with in_stall_o high until it is done.
// The output register lets the next beat be taken while a result waits; a new
// read result waits in the sequencer until it frees.
module gridded_leaflet_height_binner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [17:0]                 pos_x_i,
  input  logic [17:0]                 pos_y_i,
  input  logic signed [17:0]          rel_z_i,
  input  logic [11:0]                 read_col_i,
  input  logic [11:0]                 read_row_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [16:0]                 upper_mean_o,
  output logic                        upper_valid_o,
  output logic [16:0]                 lower_mean_o,
  output logic                        lower_valid_o,
  output logic                        read_out_of_range_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import glhb_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_QUO    = 11'b000_0000_0100,
    S_CORR   = 11'b000_0000_1000,
    S_TILE   = 11'b000_0001_0000,
    S_RD     = 11'b000_0010_0000,
    S_MOD    = 11'b000_0100_0000,
    S_DSTART = 11'b000_1000_0000,
    S_DU     = 11'b001_0000_0000,
    S_DL     = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CoordW-1:0]    min_x_q, max_x_q, min_y_q, max_y_q;
  logic [GridW-1:0]     cols_q, rows_q;
  logic [CountBits-1:0] limit_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      max_x_q <= {CoordW{1'b1}};
      min_y_q <= '0;
      max_y_q <= {CoordW{1'b1}};
      cols_q  <= GridW'(64);
      rows_q  <= GridW'(64);
      limit_q <= CountBits'(30);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegMinX:  min_x_q <= pwdata[CoordW-1:0];
        RegMaxX:  max_x_q <= pwdata[CoordW-1:0];
        RegMinY:  min_y_q <= pwdata[CoordW-1:0];
        RegMaxY:  max_y_q <= pwdata[CoordW-1:0];
        RegCols:  cols_q  <= pwdata[GridW-1:0];
        RegRows:  rows_q  <= pwdata[GridW-1:0];
        RegLimit: limit_q <= pwdata[CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegMinX:  prdata = 32'(min_x_q);
      RegMaxX:  prdata = 32'(max_x_q);
      RegMinY:  prdata = 32'(min_y_q);
      RegMaxY:  prdata = 32'(max_y_q);
      RegCols:  prdata = 32'(cols_q);
      RegRows:  prdata = 32'(rows_q);
      RegLimit: prdata = 32'(limit_q);
      default:  prdata = '0;
    endcase
  end

  // item registers
  logic                   kind_q;
  logic signed [ZW-1:0]   z_q;
  logic [OffW-1:0]        vx_q, vy_q;
  logic [BinW-1:0]        qx_q, qy_q;
  logic [BinW-1:0]        col_q, row_q;
  logic [TileAw-1:0]      tile_q;
  logic                   tok_q;
  tile_ent_t              ent_q;

  // result holding and output registers
  logic [MeanW-1:0] res_um_q, res_lm_q;
  logic             res_uv_q, res_lv_q, res_oor_q;
  logic             out_valid_q;
  logic [MeanW-1:0] out_um_q, out_lm_q;
  logic             out_uv_q, out_lv_q, out_oor_q;

  logic in_acc, out_acc, in_win, store_busy;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_win     = (pos_x_i >= min_x_q) && (pos_x_i <= max_x_q) &&
                      (pos_y_i >= min_y_q) && (pos_y_i <= max_y_q);

  // binning: reciprocal estimate, then one correction step
  logic [OffW+17:0] px, py;
  logic [OffW-1:0]  rx, ry;
  assign px = OffW'(vx_q) * BinRecip;
  assign py = OffW'(vy_q) * BinRecip;
  assign rx = vx_q - OffW'(qx_q) * OffW'(BinDiv);
  assign ry = vy_q - OffW'(qy_q) * OffW'(BinDiv);

  // tile number and range check
  logic [BinW+GridW-1:0] prod;
  logic [BinW+GridW:0]   tsum;
  logic                  tok;
  assign prod = row_q * cols_q;
  assign tsum = (BinW+GridW+1)'(prod) + (BinW+GridW+1)'(col_q);
  assign tok  = (GridW'(col_q) < cols_q) && (GridW'(row_q) < rows_q) &&
                (tsum < (BinW+GridW+1)'(MaxTiles));

  // tile store
  tile_ent_t rd_data, upd;
  logic      mem_re, mem_we;
  assign mem_re = (state_q == S_RD) && tok_q;
  assign mem_we = (state_q == S_MOD) && !kind_q;

  glhb_tile_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_re),
    .rd_addr_i (tile_q),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_we),
    .wr_addr_i (tile_q),
    .wr_data_i (upd),
    .busy_o    (store_busy)
  );

  // saturating add into the layer that the sign selects
  logic            z_pos;
  logic [SumW:0]   sel_sum, add_sum;
  logic [SumW-1:0] sat_sum;
  logic [CountBits-1:0] sel_cnt;
  assign z_pos   = !z_q[ZW-1] && (z_q != '0);
  assign sel_sum = z_pos ? {rd_data.usum[SumW-1], rd_data.usum}
                         : {rd_data.lsum[SumW-1], rd_data.lsum};
  assign sel_cnt = z_pos ? rd_data.ucnt : rd_data.lcnt;
  assign add_sum = sel_sum + (SumW+1)'(z_q);

  always_comb begin
    sat_sum = add_sum[SumW-1:0];
    if (add_sum[SumW] != add_sum[SumW-1])
      sat_sum = add_sum[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    upd = rd_data;
    if (sel_cnt != {CountBits{1'b1}}) begin
      if (z_pos) begin
        upd.usum = sat_sum;
        upd.ucnt = rd_data.ucnt + 1'b1;
      end else begin
        upd.lsum = sat_sum;
        upd.lcnt = rd_data.lcnt + 1'b1;
      end
    end
  end

  // mean divider, shared by both layers
  logic                 div_start, div_busy, div_done;
  logic [MeanW-1:0]     div_quot;
  logic signed [SumW-1:0] div_sum;
  logic [SumW-1:0]      div_mag;
  logic [CountBits-1:0] div_den;
  logic                 uvalid, lvalid, umeanok, lmeanok;

  assign div_start = (state_q == S_DSTART) || ((state_q == S_DU) && div_done);
  assign div_sum   = (state_q == S_DU) ? ent_q.lsum : ent_q.usum;
  assign div_den   = (state_q == S_DU) ? ent_q.lcnt : ent_q.ucnt;
  assign div_mag   = div_sum[SumW-1] ? SumW'(-div_sum) : SumW'(div_sum);
  assign uvalid    = ent_q.ucnt >= limit_q;
  assign lvalid    = ent_q.lcnt >= limit_q;
  assign umeanok   = uvalid && (ent_q.ucnt != '0);
  assign lmeanok   = lvalid && (ent_q.lcnt != '0);

  glhb_mean_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (!store_busy) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (kind_i)      state_d = S_TILE;
          else if (in_win) state_d = S_QUO;
        end
      end
      S_QUO:    state_d = S_CORR;
      S_CORR:   state_d = S_TILE;
      S_TILE:   state_d = S_RD;
      S_RD: begin
        if (tok_q)       state_d = S_MOD;
        else if (kind_q) state_d = S_OUT;
        else             state_d = S_IDLE;
      end
      S_MOD:    state_d = kind_q ? S_DSTART : S_IDLE;
      S_DSTART: state_d = S_DU;
      S_DU:     if (div_done) state_d = S_DL;
      S_DL:     if (div_done) state_d = S_OUT;
      S_OUT:    if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      z_q    <= rel_z_i;
      vx_q   <= OffW'(pos_x_i - min_x_q) + BinHalf;
      vy_q   <= OffW'(pos_y_i - min_y_q) + BinHalf;
      col_q  <= read_col_i;
      row_q  <= read_row_i;
    end
    if (state_q == S_QUO) begin
      qx_q <= px[RecipSh +: BinW];
      qy_q <= py[RecipSh +: BinW];
    end
    if (state_q == S_CORR) begin
      col_q <= qx_q + BinW'(rx >= OffW'(BinDiv));
      row_q <= qy_q + BinW'(ry >= OffW'(BinDiv));
    end
    if (state_q == S_TILE) begin
      tile_q <= tsum[TileAw-1:0];
      tok_q  <= tok;
    end
    if ((state_q == S_RD) && !tok_q) begin
      res_um_q  <= '0;
      res_uv_q  <= 1'b0;
      res_lm_q  <= '0;
      res_lv_q  <= 1'b0;
      res_oor_q <= 1'b1;
    end
    if (state_q == S_MOD) ent_q <= rd_data;
    if ((state_q == S_DU) && div_done) begin
      res_um_q  <= umeanok ? div_quot : '0;
      res_uv_q  <= uvalid;
      res_oor_q <= 1'b0;
    end
    if ((state_q == S_DL) && div_done) begin
      res_lm_q <= lmeanok ? div_quot : '0;
      res_lv_q <= lvalid;
    end
  end

  // output register
  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_acc)  out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_um_q  <= res_um_q;
      out_uv_q  <= res_uv_q;
      out_lm_q  <= res_lm_q;
      out_lv_q  <= res_lv_q;
      out_oor_q <= res_oor_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign upper_mean_o        = out_um_q;
  assign upper_valid_o       = out_uv_q;
  assign lower_mean_o        = out_lm_q;
  assign lower_valid_o       = out_lv_q;
  assign read_out_of_range_o = out_oor_q;

  property p_no_accept_clear;
    @(posedge clk_i) disable iff (!rst_ni) store_busy |-> in_stall_o;
  endproperty
  a_no_accept_clear: assert property (p_no_accept_clear) else $error("beat taken during clear");

  property p_write_sample;
    @(posedge clk_i) disable iff (!rst_ni) mem_we |-> $past(mem_re);
  endproperty
  a_write_sample: assert property (p_write_sample) else $error("write back without read");

  property p_div_free;
    @(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_busy;
  endproperty
  a_div_free: assert property (p_div_free) else $error("divider started while busy");

  property p_load_no_loss;
    @(posedge clk_i) disable iff (!rst_ni) out_load |-> (!out_valid_q || out_acc);
  endproperty
  a_load_no_loss: assert property (p_load_no_loss) else $error("result overwritten");

endmodule
